[hdl/assert_macros.svh]
// Assertion macros shared by the packetizer RTL.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ssp_pkg.sv]
// Types and constants of the sensor sample packetizer.
// Used by ssp_ctrl, ssp_dpath and sensor_sample_packetizer; no dependencies.
`default_nettype none

package ssp_pkg;

  localparam int unsigned CodeW = 16;
  localparam int unsigned SeqW  = 28;

  // Unit id that marks an unconfigured sender.
  localparam logic [7:0] UNKNOWN_ID_CODE = 8'd255;

  typedef enum logic [2:0] {
    CFG_FORCE_MIN      = 3'd0,
    CFG_FORCE_MAX      = 3'd1,
    CFG_FORCE_INV_SPAN = 3'd2,
    CFG_ANGLE_MIN      = 3'd3,
    CFG_ANGLE_MAX      = 3'd4,
    CFG_ANGLE_INV_SPAN = 3'd5,
    CFG_UNIT_ID        = 3'd6,
    CFG_LINK_READY     = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_FORCE  = 2'd1,
    KIND_ANGLE  = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    DROP_NONE       = 2'd0,
    DROP_UNKNOWN_ID = 2'd1,
    DROP_WIDE_ID    = 2'd2,
    DROP_LINK_DOWN  = 2'd3
  } drop_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FORCE,
    ST_ANGLE,
    ST_STORE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic signed [31:0] force_sample;
    logic signed [31:0] angle_sample;
  } in_t;

  typedef struct packed {
    kind_e       word_kind;
    logic [31:0] word_value;
    drop_e       drop_reason;
    logic        last_word;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic cap_sample;
    logic mul_angle;
    logic wr_force;
    logic wr_angle;
    logic emit_word;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic fill_last;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[hdl/ssp_ctrl.sv]
// Sequencer of the packetizer: sample intake, code writes and word emission.
// Depends on ssp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ssp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ssp_pkg::stat_t stat_i,
  output ssp_pkg::cmd_t      cmd_o
);

  ssp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ssp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_sample = 1'b1;
          state_d          = ssp_pkg::ST_FORCE;
        end
      end
      ssp_pkg::ST_FORCE: begin
        cmd_o.mul_angle = 1'b0;
        state_d         = ssp_pkg::ST_ANGLE;
      end
      ssp_pkg::ST_ANGLE: begin
        // multiply angle while the force code goes to storage
        cmd_o.mul_angle = 1'b1;
        cmd_o.wr_force  = 1'b1;
        state_d         = ssp_pkg::ST_STORE;
      end
      ssp_pkg::ST_STORE: begin
        cmd_o.wr_angle = 1'b1;
        state_d        = stat_i.fill_last ? ssp_pkg::ST_EMIT : ssp_pkg::ST_IDLE;
      end
      ssp_pkg::ST_EMIT: begin
        cmd_o.emit_word = stat_i.out_free;
        if (stat_i.out_free && stat_i.emit_last) begin
          state_d = ssp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ssp_pkg::ST_IDLE;
      end
    endcase
  end

  `ASSERT_IMPL(a_capture_to_force_write, cmd_o.cap_sample, ##2 cmd_o.wr_force,
               "force code not written two cycles after capture")
  `ASSERT_NEXT(a_force_then_angle_write, cmd_o.wr_force, cmd_o.wr_angle,
               "angle code write did not follow force code write")
  `ASSERT_IMPL(a_emit_after_full,
               (state_q == ssp_pkg::ST_EMIT) && ($past(state_q) != ssp_pkg::ST_EMIT),
               ($past(state_q) == ssp_pkg::ST_STORE) && $past(stat_i.fill_last),
               "emission started without a full packet")

endmodule

`default_nettype wire

[hdl/ssp_dpath.sv]
// Datapath of the packetizer: config registers, shared scaler, code storage,
// counters and output register. Depends on ssp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ssp_dpath #(
  parameter int unsigned SAMPLES_PER_PACKET = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ssp_pkg::cmd_t  cmd_i,
  output ssp_pkg::stat_t      stat_o,
  input  wire ssp_pkg::in_t   in_word_i,
  input  wire logic           cfg_valid_i,
  input  wire logic [2:0]     cfg_index_i,
  input  wire logic [31:0]    cfg_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ssp_pkg::out_t       out_word_o
);

  localparam int unsigned N  = SAMPLES_PER_PACKET;
  localparam int unsigned FW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned WW = $clog2(2 * N + 1);

  // Configuration registers
  logic signed [31:0] force_min_q, force_max_q, angle_min_q, angle_max_q;
  logic [31:0]        force_inv_q, angle_inv_q;
  logic [7:0]         unit_id_q;
  logic               link_ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_min_q  <= 32'sd0;
      force_max_q  <= 32'sd65536000;
      force_inv_q  <= 32'd65;
      angle_min_q  <= -32'sd11796480;
      angle_max_q  <= 32'sd11796480;
      angle_inv_q  <= 32'd182;
      unit_id_q    <= 8'd255;
      link_ready_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ssp_pkg::CFG_FORCE_MIN:      force_min_q  <= cfg_data_i;
        ssp_pkg::CFG_FORCE_MAX:      force_max_q  <= cfg_data_i;
        ssp_pkg::CFG_FORCE_INV_SPAN: force_inv_q  <= cfg_data_i;
        ssp_pkg::CFG_ANGLE_MIN:      angle_min_q  <= cfg_data_i;
        ssp_pkg::CFG_ANGLE_MAX:      angle_max_q  <= cfg_data_i;
        ssp_pkg::CFG_ANGLE_INV_SPAN: angle_inv_q  <= cfg_data_i;
        ssp_pkg::CFG_UNIT_ID:        unit_id_q    <= cfg_data_i[7:0];
        ssp_pkg::CFG_LINK_READY:     link_ready_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sample holding register
  ssp_pkg::in_t smp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_sample) begin
      smp_q <= in_word_i;
    end
  end

  // Shared scaler, stage 1: clamp compares and the product
  logic signed [31:0] s_v, s_lo, s_hi;
  logic [31:0]        s_inv, s_diff;
  logic [63:0]        prod_d, prod_q;
  logic               sat_lo_q, sat_hi_q;

  always_comb begin
    if (cmd_i.mul_angle) begin
      s_v   = smp_q.angle_sample;
      s_lo  = angle_min_q;
      s_hi  = angle_max_q;
      s_inv = angle_inv_q;
    end else begin
      s_v   = smp_q.force_sample;
      s_lo  = force_min_q;
      s_hi  = force_max_q;
      s_inv = force_inv_q;
    end
    // v above lo, so the difference fits 32 bits unsigned
    s_diff = $unsigned(s_v) - $unsigned(s_lo);
    prod_d = s_diff * s_inv;
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    sat_lo_q <= (s_v <= s_lo);
    sat_hi_q <= (s_v >= s_hi);
  end

  // Stage 2: round the fraction times 65535
  logic [47:0]                 round_sum;
  logic [ssp_pkg::CodeW-1:0]   code;

  always_comb begin
    round_sum = {prod_q[31:0], 16'h0000} - {16'h0000, prod_q[31:0]} + 48'h0000_8000_0000;
    if (sat_lo_q) begin
      code = '0;
    end else if (sat_hi_q || (prod_q[63:32] != 32'd0)) begin
      code = '1;
    end else begin
      code = round_sum[47:32];
    end
  end

  // Code storage, fill and sequence counters
  logic [ssp_pkg::CodeW-1:0] force_codes_q [N];
  logic [ssp_pkg::CodeW-1:0] angle_codes_q [N];
  logic [FW-1:0]             fill_q;
  logic [ssp_pkg::SeqW-1:0]  seq_q;
  logic [WW-1:0]             widx_q;
  logic                      fill_last;

  assign fill_last = (fill_q == FW'(N - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_force) begin
      force_codes_q[fill_q] <= code;
    end
    if (cmd_i.wr_angle) begin
      angle_codes_q[fill_q] <= code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      seq_q  <= '0;
      widx_q <= '0;
    end else begin
      if (cmd_i.wr_angle) begin
        if (fill_last) begin
          fill_q <= '0;
          seq_q  <= seq_q + 1'b1;
          widx_q <= '0;
        end else begin
          fill_q <= fill_q + 1'b1;
        end
      end else if (cmd_i.emit_word) begin
        widx_q <= widx_q + 1'b1;
      end
    end
  end

  // Drop decision: unknown id first, then wide id, then link down
  ssp_pkg::drop_e reason;

  always_comb begin
    if (unit_id_q == ssp_pkg::UNKNOWN_ID_CODE) begin
      reason = ssp_pkg::DROP_UNKNOWN_ID;
    end else if (unit_id_q > 8'd15) begin
      reason = ssp_pkg::DROP_WIDE_ID;
    end else if (!link_ready_q) begin
      reason = ssp_pkg::DROP_LINK_DOWN;
    end else begin
      reason = ssp_pkg::DROP_NONE;
    end
  end

  // Word selection
  logic [WW-1:0] widx_m1, aidx;
  logic          emit_last;
  ssp_pkg::out_t out_d, out_q;
  logic          out_valid_q;

  assign widx_m1   = widx_q - 1'b1;
  assign aidx      = widx_m1 - WW'(N);
  assign emit_last = (reason != ssp_pkg::DROP_NONE) || (widx_q == WW'(2 * N));

  always_comb begin
    out_d.drop_reason = reason;
    out_d.last_word   = emit_last;
    if (reason != ssp_pkg::DROP_NONE) begin
      out_d.word_kind  = ssp_pkg::KIND_STATUS;
      out_d.word_value = '0;
    end else if (widx_q == '0) begin
      out_d.word_kind  = ssp_pkg::KIND_HEADER;
      out_d.word_value = {unit_id_q[3:0], seq_q};
    end else if (widx_q <= WW'(N)) begin
      out_d.word_kind  = ssp_pkg::KIND_FORCE;
      out_d.word_value = {16'h0000, force_codes_q[widx_m1[FW-1:0]]};
    end else begin
      out_d.word_kind  = ssp_pkg::KIND_ANGLE;
      out_d.word_value = {16'h0000, angle_codes_q[aidx[FW-1:0]]};
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_word) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_word) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_word_o       = out_q;
  assign stat_o.fill_last = fill_last;
  assign stat_o.emit_last = emit_last;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  `ASSERT_IMPL(a_fill_range, 1'b1, fill_q <= FW'(N - 1), "fill count out of range")
  `ASSERT_NEXT(a_seq_step, cmd_i.wr_angle && fill_last,
               seq_q == $past(seq_q) + 1'b1, "sequence did not advance on full packet")
  `ASSERT_IMPL(a_status_single, out_valid_q && (out_q.word_kind == ssp_pkg::KIND_STATUS),
               out_q.last_word && (out_q.drop_reason != ssp_pkg::DROP_NONE),
               "drop status is not a single final word")

endmodule

`default_nettype wire

[hdl/sensor_sample_packetizer.sv]
// Sensor sample packetizer: scales force/angle sample pairs to 16-bit codes
// and sends them in packets. Top level; uses ssp_pkg, ssp_ctrl, ssp_dpath.
//
// Usage:
// - Input channel (in_valid_i/in_ready_o/in_word_i) takes one word holding a
//   force and an angle sample, signed Q16.16.
// - Each sample pair passes the accept step, a force multiply, an angle
//   multiply (force code written) and the angle code write before the next
//   pair is taken. One 32x32 multiplier is shared by both channels.
// - After every SAMPLES_PER_PACKET pairs the sequence advances and the block
//   emits either a packet (header, force codes, angle codes: 2N+1 words) or a
//   single drop-status word, at one word per cycle while out_ready_i is high.
//   The first word is registered in the emit state after the last code write.
//   No input is taken during emission; the next pair is taken as soon as the
//   final word sits in the output register.
// - A stalled receiver holds the output register and its payload; emission
//   pauses with it.
// - Configuration (cfg_valid_i/cfg_ready_o) is always ready; write only while
//   the block is idle. Reset restores register defaults and clears the fill
//   and sequence counts; code storage is not cleared.
`default_nettype none

module sensor_sample_packetizer #(
  parameter int unsigned SAMPLES_PER_PACKET = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ssp_pkg::in_t  in_word_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ssp_pkg::out_t      out_word_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [2:0]    cfg_index_i,
  input  wire logic [31:0]   cfg_data_i
);

  ssp_pkg::cmd_t  cmd;
  ssp_pkg::stat_t stat;

  // config writes go straight into the registers at the next clock edge
  assign cfg_ready_o = 1'b1;

  ssp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ssp_dpath #(
    .SAMPLES_PER_PACKET (SAMPLES_PER_PACKET)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_word_i   (in_word_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
